// ===== src/kaf_pkg.sv =====
// Shared constants, types and a saturation helper function for the angle Kalman filter.
package kaf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NOISE_W       = 16;
  localparam int ANGLE_W       = 16;
  localparam int MS_W          = 10;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 16'd655;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 16'd20;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 16'd655;

  // Datapath operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
  localparam logic [OP_W-1:0] OP_ANG_P   = 5'd2;
  localparam logic [OP_W-1:0] OP_AA_P1   = 5'd3;
  localparam logic [OP_W-1:0] OP_AA_P2   = 5'd4;
  localparam logic [OP_W-1:0] OP_AB_P    = 5'd5;
  localparam logic [OP_W-1:0] OP_BA_P    = 5'd6;
  localparam logic [OP_W-1:0] OP_BB_P    = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV0    = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV1    = 5'd9;
  localparam logic [OP_W-1:0] OP_ANG_U   = 5'd10;
  localparam logic [OP_W-1:0] OP_BIAS_U  = 5'd11;
  localparam logic [OP_W-1:0] OP_AA_U    = 5'd12;
  localparam logic [OP_W-1:0] OP_AB_U    = 5'd13;
  localparam logic [OP_W-1:0] OP_BA_U    = 5'd14;
  localparam logic [OP_W-1:0] OP_BB_U    = 5'd15;
  localparam logic [OP_W-1:0] OP_AA_P0   = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_start;
  } kaf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } kaf_sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [2*DATA_W-1:0] v);
    logic signed [2*DATA_W-1:0] mx;
    logic signed [2*DATA_W-1:0] mn;
    mx = (2*DATA_W)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    mn = -mx - (2*DATA_W)'(1);
    if (v > mx) return mx[DATA_W-1:0];
    if (v < mn) return mn[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== src/kalman_angle_filter.sv =====
// Top level of the two-state angle and gyro-bias Kalman filter.
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    measured_angle, measured_rate, loop_time_ms
//   out_     output     out_valid/out_stall  angle_estimate, bias_estimate
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
// The interval from one accepted item to the next, when the output does not stall, is
// set mostly by two serial gain divisions of 48 steps each.
// Reset clears the state and covariance to zero and restores the default noise values.
// A new item is taken only after the previous result has been taken.
module kalman_angle_filter #(
  parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [kaf_pkg::ANGLE_W-1:0]  in_measured_angle,
  input  logic signed [kaf_pkg::ANGLE_W-1:0]  in_measured_rate,
  input  logic [kaf_pkg::MS_W-1:0]            in_loop_time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [kaf_pkg::DATA_W-1:0]   out_angle_estimate,
  output logic signed [kaf_pkg::DATA_W-1:0]   out_bias_estimate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kaf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kaf_pkg::NOISE_W-1:0]         cfg_data
);
  import kaf_pkg::*;

  logic [NOISE_W-1:0] qa_r, qb_r, rn_r;
  kaf_cmd_t cmd;
  kaf_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= ANGLE_NOISE_RST; qb_r <= BIAS_NOISE_RST; rn_r <= MEAS_NOISE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ANGLE_NOISE: qa_r <= cfg_data;
        CFG_BIAS_NOISE:  qb_r <= cfg_data;
        CFG_MEAS_NOISE:  rn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  kaf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  kaf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .measured_angle(in_measured_angle), .measured_rate(in_measured_rate),
    .loop_time_ms(in_loop_time_ms), .qa_cfg(qa_r), .qb_cfg(qb_r), .r_cfg(rn_r),
    .angle_q(out_angle_estimate), .bias_q(out_bias_estimate)
  );
endmodule

// ===== src/kaf_divider.sv =====
// Restoring serial divider for the gain, one quotient bit per cycle, signed truncating.
module kaf_divider #(
  parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [kaf_pkg::DATA_W-1:0]   numer,
  input  logic signed [kaf_pkg::DATA_W+1:0]   denom,
  output logic                                busy,
  output logic signed [kaf_pkg::DATA_W-1:0]   quot
);
  import kaf_pkg::*;

  localparam int NW  = DATA_W + FRAC_BITS;
  localparam int DW  = DATA_W + 2;
  localparam int CW  = $clog2(NW + 1);
  localparam logic signed [NW:0] QMAX = (NW+1)'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [NW:0] QMIN = ~QMAX;

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic          zero_r, zero_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic [NW-1:0]       nabs;
  logic [DW-1:0]       dabs;
  logic [DW:0]         trial;
  logic signed [NW:0]  sq;

  always_comb begin
    nabs = numer[DATA_W-1] ? NW'(-{{FRAC_BITS{numer[DATA_W-1]}}, numer}) :
                             NW'({{FRAC_BITS{1'b0}}, numer});
    nabs = NW'(nabs << FRAC_BITS);
    dabs = denom[DW-1] ? DW'(-denom) : DW'(denom);
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r; zero_nxt = zero_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = nabs; rem_nxt = '0; d_nxt = dabs;
      neg_nxt = numer[DATA_W-1] ^ denom[DW-1];
      zero_nxt = (denom == '0);
      cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
    sq = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt; zero_r <= zero_nxt;
  end

  assign busy = busy_r;
  assign quot = zero_r ? '0 :
                (sq > QMAX) ? QMAX[DATA_W-1:0] :
                (sq < QMIN) ? QMIN[DATA_W-1:0] : sq[DATA_W-1:0];
endmodule

// ===== src/kaf_datapath.sv =====
// Filter state registers, shared multiplier and update arithmetic.
module kaf_datapath #(
  parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kaf_pkg::kaf_cmd_t                   cmd,
  output kaf_pkg::kaf_sts_t                   sts,
  input  logic signed [kaf_pkg::ANGLE_W-1:0]  measured_angle,
  input  logic signed [kaf_pkg::ANGLE_W-1:0]  measured_rate,
  input  logic [kaf_pkg::MS_W-1:0]            loop_time_ms,
  input  logic [kaf_pkg::NOISE_W-1:0]         qa_cfg,
  input  logic [kaf_pkg::NOISE_W-1:0]         qb_cfg,
  input  logic [kaf_pkg::NOISE_W-1:0]         r_cfg,
  output logic signed [kaf_pkg::DATA_W-1:0]   angle_q,
  output logic signed [kaf_pkg::DATA_W-1:0]   bias_q
);
  import kaf_pkg::*;

  localparam int W  = DATA_W;
  localparam int PW = 2 * W;
  localparam int EW = PW;
  localparam int DTW = MS_W + FRAC_BITS + 1;
  // The loop time scale splits as 2^F = 1000 * DT_A + DT_B; the remainder part is
  // divided by 1000 through a reciprocal multiply that is exact below 2^DT_LW.
  localparam int DT_A  = (1 << FRAC_BITS) / 1000;
  localparam int DT_B  = (1 << FRAC_BITS) % 1000;
  localparam int DT_LW = 20;
  localparam int DT_K  = 30;
  localparam int DT_M  = 1073742;
  localparam int DT_PW = DT_LW + 21;

  logic signed [W-1:0] ang_r, bias_r, aa_r, ab_r, ba_r, bb_r, k0_r, k1_r;
  logic signed [W-1:0] ang_nxt, bias_nxt, aa_nxt, ab_nxt, ba_nxt, bb_nxt, k0_nxt, k1_nxt;
  logic signed [EW-1:0] tmp_r, tmp_nxt, meas_r, meas_nxt;
  logic signed [W-1:0] dt_r, y_r;
  logic signed [W-1:0] dt_nxt, y_nxt;

  logic signed [W-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] qm;
  logic signed [EW-1:0] qmx;
  logic [DT_LW-1:0] dt_lo;
  logic [DT_PW-1:0] dt_qp;
  logic [DTW-1:0] dtw;
  logic signed [W-1:0] qa_q, qb_q, r_q;
  logic signed [W-1:0] dq;
  logic signed [W+1:0] s_den;

  assign qa_q = W'((48'(qa_cfg) << FRAC_BITS) >> NOISE_W);
  assign qb_q = W'((48'(qb_cfg) << FRAC_BITS) >> NOISE_W);
  assign r_q  = W'((48'(r_cfg)  << FRAC_BITS) >> NOISE_W);
  assign s_den = (W+2)'(aa_r) + (W+2)'(r_q);

  kaf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .numer((cmd.op == OP_DIV1) ? ba_r : aa_r), .denom(s_den),
    .busy(sts.div_busy), .quot(dq)
  );

  always_comb begin
    ma = '0; mb = '0;
    case (cmd.op)
      OP_ANG_P: begin ma = dt_r; mb = W'(tmp_r); end
      OP_AA_P1: begin ma = dt_r; mb = W'(tmp_r); end
      OP_AA_P2: begin ma = qa_q; mb = dt_r; end
      OP_AB_P, OP_BA_P: begin ma = dt_r; mb = bb_r; end
      OP_BB_P:  begin ma = qb_q; mb = dt_r; end
      OP_ANG_U: begin ma = k0_r; mb = y_r; end
      OP_BIAS_U: begin ma = k1_r; mb = y_r; end
      OP_AA_U:  begin ma = k0_r; mb = aa_r; end
      OP_AB_U:  begin ma = k0_r; mb = ab_r; end
      OP_BA_U:  begin ma = k1_r; mb = aa_r; end
      OP_BB_U:  begin ma = k1_r; mb = ab_r; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = PW'(ma) * PW'(mb);
    qm = (prod + PW'(2**(FRAC_BITS-1))) >>> FRAC_BITS;
    qmx = EW'(qm);
  end

  always_comb begin
    ang_nxt = ang_r; bias_nxt = bias_r; aa_nxt = aa_r; ab_nxt = ab_r; ba_nxt = ba_r;
    bb_nxt = bb_r; k0_nxt = k0_r; k1_nxt = k1_r; tmp_nxt = tmp_r;
    dt_nxt = dt_r; y_nxt = y_r; meas_nxt = meas_r;
    dt_lo = DT_LW'({{(DT_LW-MS_W){1'b0}}, loop_time_ms} * DT_LW'(DT_B)) + DT_LW'(500);
    dt_qp = {{(DT_PW-DT_LW){1'b0}}, dt_lo} * DT_PW'(DT_M);
    dtw = DTW'({{(DTW-MS_W){1'b0}}, loop_time_ms} * DTW'(DT_A)) +
          DTW'(dt_qp[DT_PW-1:DT_K]);
    case (cmd.op)
      OP_LOAD: begin
        dt_nxt = W'(dtw);
        meas_nxt = EW'(measured_angle) <<< FRAC_BITS;
        tmp_nxt = EW'(sat32((EW'(measured_rate) <<< FRAC_BITS) - EW'(bias_r)));
      end
      OP_ANG_P: begin
        ang_nxt = sat32(EW'(ang_r) + qmx);
        tmp_nxt = EW'(sat32(EW'(ba_r) + EW'(ab_r)));
      end
      OP_AA_P1: tmp_nxt = EW'(aa_r) - qmx;
      OP_AA_P2: aa_nxt = sat32(tmp_r + qmx);
      OP_AB_P:  ab_nxt = sat32(EW'(ab_r) - qmx);
      OP_BA_P:  ba_nxt = sat32(EW'(ba_r) - qmx);
      OP_BB_P: begin
        bb_nxt = sat32(EW'(bb_r) + qmx);
        y_nxt = sat32(meas_r - EW'(ang_r));
      end
      OP_DIV0:  k0_nxt = dq;
      OP_DIV1:  k1_nxt = dq;
      OP_ANG_U: ang_nxt = sat32(EW'(ang_r) + qmx);
      OP_BIAS_U: bias_nxt = sat32(EW'(bias_r) + qmx);
      OP_AA_U:  aa_nxt = sat32(EW'(aa_r) - qmx);
      OP_AB_U:  ab_nxt = sat32(EW'(ab_r) - qmx);
      OP_BA_U:  ba_nxt = sat32(EW'(ba_r) - qmx);
      OP_BB_U:  bb_nxt = sat32(EW'(bb_r) - qmx);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0; bias_r <= '0; aa_r <= '0; ab_r <= '0; ba_r <= '0; bb_r <= '0;
    end else begin
      ang_r <= ang_nxt; bias_r <= bias_nxt; aa_r <= aa_nxt; ab_r <= ab_nxt;
      ba_r <= ba_nxt; bb_r <= bb_nxt;
    end
    k0_r <= k0_nxt; k1_r <= k1_nxt; tmp_r <= tmp_nxt; dt_r <= dt_nxt; y_r <= y_nxt;
    meas_r <= meas_nxt;
  end

  assign angle_q = ang_r;
  assign bias_q  = bias_r;
endmodule

// ===== src/kaf_ctrl.sv =====
// Sequencer that steps the datapath through predict, gain and update for one item.
module kaf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output kaf_pkg::kaf_cmd_t cmd,
  input  kaf_pkg::kaf_sts_t sts
);
  import kaf_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_ANGP  = 5'd2;
  localparam logic [4:0] S_AAP1  = 5'd3;
  localparam logic [4:0] S_AAP2  = 5'd4;
  localparam logic [4:0] S_ABP   = 5'd5;
  localparam logic [4:0] S_BAP   = 5'd6;
  localparam logic [4:0] S_BBP   = 5'd7;
  localparam logic [4:0] S_D0GO  = 5'd8;
  localparam logic [4:0] S_D0W   = 5'd9;
  localparam logic [4:0] S_D1GO  = 5'd10;
  localparam logic [4:0] S_D1W   = 5'd11;
  localparam logic [4:0] S_ANGU  = 5'd12;
  localparam logic [4:0] S_BIASU = 5'd13;
  localparam logic [4:0] S_AAU   = 5'd14;
  localparam logic [4:0] S_ABU   = 5'd15;
  localparam logic [4:0] S_BAU   = 5'd16;
  localparam logic [4:0] S_BBU   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;
  localparam logic [4:0] S_D0S   = 5'd19;
  localparam logic [4:0] S_D1S   = 5'd20;

  logic [4:0] st_r, st_nxt;

  assign in_stall  = !rst_n || (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    st_nxt = st_r;
    cmd.op = OP_NOP;
    cmd.div_start = 1'b0;
    case (st_r)
      S_IDLE:  if (in_valid) begin st_nxt = S_ANGP; cmd.op = OP_LOAD; end
      S_ANGP:  begin cmd.op = OP_ANG_P; st_nxt = S_AAP1; end
      S_AAP1:  begin cmd.op = OP_AA_P1; st_nxt = S_AAP2; end
      S_AAP2:  begin cmd.op = OP_AA_P2; st_nxt = S_ABP; end
      S_ABP:   begin cmd.op = OP_AB_P; st_nxt = S_BAP; end
      S_BAP:   begin cmd.op = OP_BA_P; st_nxt = S_BBP; end
      S_BBP:   begin cmd.op = OP_BB_P; st_nxt = S_D0GO; end
      S_D0GO:  begin cmd.op = OP_NOP; cmd.div_start = 1'b1; st_nxt = S_D0S; end
      S_D0S:   st_nxt = S_D0W;
      S_D0W:   if (!sts.div_busy) begin cmd.op = OP_DIV0; st_nxt = S_D1GO; end
      S_D1GO:  begin cmd.op = OP_DIV1; cmd.div_start = 1'b1; st_nxt = S_D1S; end
      S_D1S:   begin cmd.op = OP_NOP; st_nxt = S_D1W; end
      S_D1W:   if (!sts.div_busy) begin cmd.op = OP_DIV1; st_nxt = S_ANGU; end
      S_ANGU:  begin cmd.op = OP_ANG_U; st_nxt = S_BIASU; end
      S_BIASU: begin cmd.op = OP_BIAS_U; st_nxt = S_AAU; end
      S_AAU:   begin cmd.op = OP_AA_U; st_nxt = S_ABU; end
      S_ABU:   begin cmd.op = OP_AB_U; st_nxt = S_BAU; end
      S_BAU:   begin cmd.op = OP_BA_U; st_nxt = S_BBU; end
      S_BBU:   begin cmd.op = OP_BB_U; st_nxt = S_OUT; end
      S_OUT:   if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the two-state angle and gyro-bias Kalman filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kaf_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] rate;
    logic [MS_W-1:0] ms;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle;
    logic signed [DATA_W-1:0] bias;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANGLE_W-1:0] in_measured_angle = '0;
  logic signed [ANGLE_W-1:0] in_measured_rate = '0;
  logic [MS_W-1:0] in_loop_time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_angle_estimate;
  logic signed [DATA_W-1:0] out_bias_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NOISE_W-1:0] cfg_data = '0;

  kalman_angle_filter DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sample_t pending_samples[$];
  estimate_t expected_estimates[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  bit burst_mode = 1'b1;
  bit in_taken = 1'b0;

  logic [NOISE_W-1:0] q_angle, q_bias, r_meas;
  longint st_angle, st_bias, p_aa, p_ab, p_ba, p_bb;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FB - 1));
    return p >>> FB;
  endfunction

  task automatic filter_reset();
    q_angle = ANGLE_NOISE_RST;
    q_bias = BIAS_NOISE_RST;
    r_meas = MEAS_NOISE_RST;
    st_angle = 0; st_bias = 0;
    p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
  endtask

  task automatic filter_step(sample_t s);
    longint dt, qa, qb, r, t, y, sum, k0, k1;
    estimate_t e;
    dt = ((longint'(s.ms) <<< FB) + 500) / 1000;
    qa = (longint'(q_angle) <<< FB) >>> 16;
    qb = (longint'(q_bias) <<< FB) >>> 16;
    r = (longint'(r_meas) <<< FB) >>> 16;
    t = clamp32((longint'(s.rate) <<< FB) - st_bias);
    st_angle = clamp32(st_angle + fx_mul(dt, t));
    t = clamp32(p_ba + p_ab);
    p_aa = clamp32(p_aa - fx_mul(dt, t) + fx_mul(qa, dt));
    p_ab = clamp32(p_ab - fx_mul(dt, p_bb));
    p_ba = clamp32(p_ba - fx_mul(dt, p_bb));
    p_bb = clamp32(p_bb + fx_mul(qb, dt));
    y = clamp32((longint'(s.angle) <<< FB) - st_angle);
    sum = p_aa + r;
    if (sum == 0) begin
      k0 = 0;
      k1 = 0;
    end else begin
      k0 = clamp32((p_aa <<< FB) / sum);
      k1 = clamp32((p_ba <<< FB) / sum);
    end
    st_angle = clamp32(st_angle + fx_mul(k0, y));
    st_bias = clamp32(st_bias + fx_mul(k1, y));
    p_aa = clamp32(p_aa - fx_mul(k0, p_aa));
    p_ab = clamp32(p_ab - fx_mul(k0, p_ab));
    p_ba = clamp32(p_ba - fx_mul(k1, p_aa));
    p_bb = clamp32(p_bb - fx_mul(k1, p_ab));
    e.angle = st_angle[31:0];
    e.bias = st_bias[31:0];
    expected_estimates.push_back(e);
  endtask

  // Sender: bursts of random length separated by random gaps, plus random output stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
      end else if (pending_samples.size() == 0) begin
        in_valid <= 1'b0;
      end else if (burst_mode && burst_left == 0 && gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        sample_t s;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end
        burst_left = burst_left - 1;
        s = pending_samples.pop_front();
        filter_step(s);
        in_valid <= 1'b1;
        in_measured_angle <= s.angle;
        in_measured_rate <= s.rate;
        in_loop_time_ms <= s.ms;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  // Monitor: results and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("tb failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_estimates.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result angle %0d bias %0d", $time,
                   out_angle_estimate, out_bias_estimate);
        end else begin
          estimate_t e;
          e = expected_estimates.pop_front();
          if (e.angle !== out_angle_estimate) begin
            errors = errors + 1;
            $display("%0t: angle expected %0d actual %0d", $time, e.angle,
                     out_angle_estimate);
          end
          if (e.bias !== out_bias_estimate) begin
            errors = errors + 1;
            $display("%0t: bias expected %0d actual %0d", $time, e.bias,
                     out_bias_estimate);
          end
        end
      end
    end
  end

  function automatic sample_t make_sample(int a, int r, int m);
    sample_t s;
    s.angle = a[15:0];
    s.rate = r[15:0];
    s.ms = m[9:0];
    return s;
  endfunction

  function automatic sample_t random_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7)
      return make_sample($urandom_range(0, 180) - 90, $urandom_range(0, 500) - 250,
                         $urandom_range(1, 40));
    return make_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 1023));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ANGLE_NOISE: q_angle = value;
      CFG_BIAS_NOISE: q_bias = value;
      default: r_meas = value;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || expected_estimates.size() != 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    filter_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at default noise.
    pending_samples.push_back(make_sample(0, 0, 0));
    pending_samples.push_back(make_sample(32767, 32767, 1000));
    pending_samples.push_back(make_sample(-32768, -32768, 1000));
    pending_samples.push_back(make_sample(-32768, 32767, 1023));
    pending_samples.push_back(make_sample(32767, -32768, 1001));
    pending_samples.push_back(make_sample(10, 5, 10));
    pending_samples.push_back(make_sample(-1, -1, 1));
    pending_samples.push_back(make_sample(21845, -21846, 682));
    pending_samples.push_back(make_sample(-21846, 21845, 341));
    pending_samples.push_back(make_sample(0, 0, 0));
    drain();

    // Zero noise with zero covariance gives a zero divisor.
    write_reg(CFG_ANGLE_NOISE, 16'd0);
    write_reg(CFG_BIAS_NOISE, 16'd0);
    write_reg(CFG_MEAS_NOISE, 16'd0);
    for (int i = 0; i < 4; i++) pending_samples.push_back(make_sample(50, 3, 0));
    pending_samples.push_back(make_sample(50, 3, 20));
    pending_samples.push_back(make_sample(-50, -3, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ANGLE_NOISE, 16'hFFFF);
          write_reg(CFG_BIAS_NOISE, 16'hFFFF);
          write_reg(CFG_MEAS_NOISE, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
          write_reg(CFG_BIAS_NOISE, BIAS_NOISE_RST);
          write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
        end
        2: begin
          write_reg(CFG_ANGLE_NOISE, 16'hAAAA);
          write_reg(CFG_BIAS_NOISE, 16'h5555);
          write_reg(CFG_MEAS_NOISE, 16'd1);
        end
        default: begin
          write_reg(CFG_ANGLE_NOISE, $urandom_range(0, 65535));
          write_reg(CFG_BIAS_NOISE, $urandom_range(0, 65535));
          write_reg(CFG_MEAS_NOISE, $urandom_range(0, 65535));
        end
      endcase
      for (int i = 0; i < 280; i++) pending_samples.push_back(random_sample());
      drain();
    end

    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule

// ===== files.f =====
src/kaf_pkg.sv
src/kaf_divider.sv
src/kaf_datapath.sv
src/kaf_ctrl.sv
src/kalman_angle_filter.sv
bench/tb.sv
